// ===== sv/jmn_pkg.sv =====
package jmn_pkg;

   localparam int PAGES = 8;
   localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;

   localparam int CSR_AW = 3;
   localparam int CSR_DW = 16;

   localparam logic [1:0] MENU_VIEW = 2'd3;

   typedef enum logic [CSR_AW-1:0] {
      REG_CENTER_X      = 3'd0,
      REG_CENTER_Y      = 3'd1,
      REG_DEADBAND      = 3'd2,
      REG_INITIAL_DELAY = 3'd3,
      REG_REPEAT_DELAY  = 3'd4,
      REG_PERF_VIEW     = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      DIR_NONE = 2'b00,
      DIR_POS  = 2'b01,
      DIR_NEG  = 2'b11
   } dir_type;

   typedef struct packed {
      logic [11:0] center_x;
      logic [11:0] center_y;
      logic [10:0] deadband;
      logic [15:0] initial_delay;
      logic [15:0] repeat_delay;
      logic [1:0]  perf_view;
   } cfg_type;

   typedef struct packed {
      logic fire;
      logic neg;
   } axis_evt_type;

   // step a non-menu view by one modulo 3, a view of 3 wraps as 0
   function automatic logic [1:0] next_view(input logic [1:0] view, input logic neg);
      logic [1:0] res;
      res = 2'd0;
      case (view)
         2'd0: res = neg ? 2'd2 : 2'd1;
         2'd1: res = neg ? 2'd0 : 2'd2;
         2'd2: res = neg ? 2'd1 : 2'd0;
         default: res = neg ? 2'd2 : 2'd1;
      endcase
      return res;
   endfunction

endpackage

// ===== sv/jmn_axis.sv =====
module jmn_axis (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  inhibit,
   input  logic [11:0]           sample,
   input  logic [11:0]           center,
   input  logic [10:0]           deadband,
   input  logic [15:0]           initial_delay,
   input  logic [15:0]           repeat_delay,
   input  logic [31:0]           now,
   output jmn_pkg::axis_evt_type evt
);
   import jmn_pkg::*;

   dir_type     dir_ff, dir_in, dir_new;
   logic        armed_ff, armed_in, armed_eff;
   logic [31:0] due_ff, due_in;
   logic [9:0]  release_dist;
   logic [12:0] sample_w, center_w;
   logic [12:0] sample_enter, center_enter, sample_rel, center_rel;
   logic        fire;

   assign release_dist = deadband[10:1];
   assign sample_w     = {1'b0, sample};
   assign center_w     = {1'b0, center};
   assign sample_enter = sample_w + {2'b00, deadband};
   assign center_enter = center_w + {2'b00, deadband};
   assign sample_rel   = sample_w + {3'b000, release_dist};
   assign center_rel   = center_w + {3'b000, release_dist};

   // hysteresis: enter past the deadband, release inside half of it
   always_comb begin
      if (center_w > sample_enter) begin
         dir_new = DIR_NEG;
      end else if (sample_w > center_enter) begin
         dir_new = DIR_POS;
      end else if (dir_ff == DIR_NEG && center_w > sample_rel) begin
         dir_new = DIR_NEG;
      end else if (dir_ff == DIR_POS && sample_w > center_rel) begin
         dir_new = DIR_POS;
      end else begin
         dir_new = DIR_NONE;
      end
   end

   always_comb begin
      armed_eff = (dir_new == dir_ff) ? armed_ff : 1'b0;
      fire      = 1'b0;
      dir_in    = dir_new;
      armed_in  = armed_eff;
      due_in    = due_ff;
      if (inhibit) begin
         dir_in   = DIR_NONE;
         armed_in = 1'b0;
      end else if (dir_new != DIR_NONE && (!armed_eff || now >= due_ff)) begin
         fire     = 1'b1;
         armed_in = 1'b1;
         due_in   = now + {16'h0000, armed_eff ? repeat_delay : initial_delay};
      end
   end

   assign evt.fire = fire;
   assign evt.neg  = (dir_new == DIR_NEG);

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff   <= DIR_NONE;
         armed_ff <= 1'b0;
         due_ff   <= '0;
      end else if (step) begin
         dir_ff   <= dir_in;
         armed_ff <= armed_in;
         due_ff   <= due_in;
      end
   end

endmodule

// ===== sv/jmn_nav.sv =====
module jmn_nav (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  jmn_pkg::axis_evt_type evt_x,
   input  jmn_pkg::axis_evt_type evt_y,
   input  logic [1:0]            perf_view,
   output logic                  menu_mode,
   output logic [1:0]            view_mode,
   output logic [2:0]            active_page,
   output logic                  fired_x,
   output logic                  fired_y
);
   import jmn_pkg::*;

   localparam logic [PAGE_W-1:0] LAST_PAGE = PAGE_W'(PAGES - 1);
   localparam logic [PAGE_W-1:0] ONE_PAGE  = PAGE_W'(1);

   logic              menu_ff, menu_in;
   logic [1:0]        view_ff, view_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic              fired_x_ff, fired_y_ff;

   // x is handled before y on the same item
   always_comb begin
      menu_in = menu_ff;
      view_in = view_ff;
      page_in = page_ff;
      if (evt_x.fire) begin
         if (!menu_ff) begin
            menu_in = 1'b1;
            view_in = MENU_VIEW;
         end
         if (evt_x.neg) begin
            if (page_ff != '0) begin
               page_in = page_ff - ONE_PAGE;
            end
         end else if (page_ff != LAST_PAGE) begin
            page_in = page_ff + ONE_PAGE;
         end
      end
      if (evt_y.fire) begin
         if (menu_in) begin
            menu_in = 1'b0;
            view_in = perf_view;
         end else begin
            view_in = next_view(view_in, evt_y.neg);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         menu_ff    <= 1'b0;
         view_ff    <= 2'd0;
         page_ff    <= '0;
         fired_x_ff <= 1'b0;
         fired_y_ff <= 1'b0;
      end else if (step) begin
         menu_ff    <= menu_in;
         view_ff    <= view_in;
         page_ff    <= page_in;
         fired_x_ff <= evt_x.fire;
         fired_y_ff <= evt_y.fire;
      end
   end

   assign menu_mode   = menu_ff;
   assign view_mode   = view_ff;
   assign active_page = 3'(page_ff);
   assign fired_x     = fired_x_ff;
   assign fired_y     = fired_y_ff;

endmodule

// ===== sv/joystick_menu_navigator_unit.sv =====
// Joystick menu navigator. Takes one joystick item per cycle while the result
// side is ready and returns one result item for each, held while the result
// side is not ready: the item is held in an input register, then the axis
// hysteresis, repeat timers and menu state are updated together as the item
// advances, and the result register is the updated menu, view and page state
// plus the fire flags. Sustained rate is one item per cycle while the result
// side is ready. Configuration writes via csr_we/csr_addr/csr_wdata take
// effect at once and are meant to be made while the block is idle; unused
// register indexes are ignored.
module joystick_menu_navigator_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [11:0]                 req_joy_x,
   input  logic [11:0]                 req_joy_y,
   input  logic                        req_inhibit,
   input  logic [31:0]                 req_now_ms,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_menu_mode,
   output logic [1:0]                  rsp_view_mode,
   output logic [2:0]                  rsp_active_page,
   output logic                        rsp_fired_x,
   output logic                        rsp_fired_y,
   input  logic                        csr_we,
   input  logic [jmn_pkg::CSR_AW-1:0]  csr_addr,
   input  logic [jmn_pkg::CSR_DW-1:0]  csr_wdata
);
   import jmn_pkg::*;

   cfg_type      cfg_ff;
   logic         in_valid_ff, in_valid_in;
   logic         out_valid_ff, out_valid_in;
   logic [11:0]  joy_x_ff, joy_y_ff;
   logic         inhibit_ff;
   logic [31:0]  now_ff;
   logic         advance;
   axis_evt_type evt_x, evt_y;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         joy_x_ff   <= req_joy_x;
         joy_y_ff   <= req_joy_y;
         inhibit_ff <= req_inhibit;
         now_ff     <= req_now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_x      <= 12'd2048;
         cfg_ff.center_y      <= 12'd2048;
         cfg_ff.deadband      <= 11'd150;
         cfg_ff.initial_delay <= 16'd300;
         cfg_ff.repeat_delay  <= 16'd250;
         cfg_ff.perf_view     <= 2'd0;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_addr))
            REG_CENTER_X:      cfg_ff.center_x      <= csr_wdata[11:0];
            REG_CENTER_Y:      cfg_ff.center_y      <= csr_wdata[11:0];
            REG_DEADBAND:      cfg_ff.deadband      <= csr_wdata[10:0];
            REG_INITIAL_DELAY: cfg_ff.initial_delay <= csr_wdata;
            REG_REPEAT_DELAY:  cfg_ff.repeat_delay  <= csr_wdata;
            REG_PERF_VIEW:     cfg_ff.perf_view     <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   jmn_axis u_axis_x (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .inhibit       (inhibit_ff),
      .sample        (joy_x_ff),
      .center        (cfg_ff.center_x),
      .deadband      (cfg_ff.deadband),
      .initial_delay (cfg_ff.initial_delay),
      .repeat_delay  (cfg_ff.repeat_delay),
      .now           (now_ff),
      .evt           (evt_x)
   );

   jmn_axis u_axis_y (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .inhibit       (inhibit_ff),
      .sample        (joy_y_ff),
      .center        (cfg_ff.center_y),
      .deadband      (cfg_ff.deadband),
      .initial_delay (cfg_ff.initial_delay),
      .repeat_delay  (cfg_ff.repeat_delay),
      .now           (now_ff),
      .evt           (evt_y)
   );

   jmn_nav u_nav (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .evt_x       (evt_x),
      .evt_y       (evt_y),
      .perf_view   (cfg_ff.perf_view),
      .menu_mode   (rsp_menu_mode),
      .view_mode   (rsp_view_mode),
      .active_page (rsp_active_page),
      .fired_x     (rsp_fired_x),
      .fired_y     (rsp_fired_y)
   );

   assign rsp_valid = out_valid_ff;

endmodule

// ===== sv/jmn_checker.sv =====
module jmn_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_menu_mode,
   input logic [1:0]                  rsp_view_mode,
   input logic [2:0]                  rsp_active_page,
   input logic                        rsp_fired_x,
   input logic                        rsp_fired_y
);
   import jmn_pkg::*;

   // a stalled result item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_menu_mode)
         && $stable(rsp_view_mode) && $stable(rsp_active_page)
         && $stable(rsp_fired_x) && $stable(rsp_fired_y))
      else $error("stalled result item changed");

   // menu shown means the menu view
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_menu_mode |-> rsp_view_mode == MENU_VIEW)
      else $error("menu mode without menu view");

   // a y action always leaves the menu
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fired_y |-> !rsp_menu_mode)
      else $error("menu still shown after y action");

   // an x action alone always ends in the menu
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fired_x && !rsp_fired_y |-> rsp_menu_mode)
      else $error("menu not shown after x action");

endmodule

bind joystick_menu_navigator_unit jmn_checker u_jmn_checker (.*);

// ===== tb/joystick_menu_navigator_unit_test.sv =====
`timescale 1ns / 100ps

import jmn_pkg::*;

typedef struct packed {
   logic [11:0] joy_x;
   logic [11:0] joy_y;
   logic        inhibit;
   logic [31:0] now_ms;
} joy_sample_t;

typedef struct packed {
   logic       menu_mode;
   logic [1:0] view_mode;
   logic [2:0] active_page;
   logic       fired_x;
   logic       fired_y;
} screen_t;

typedef struct packed {
   dir_type     dir;
   logic        armed;
   logic [31:0] due;
} axis_state_t;

class menu_nav_tracker;
   localparam int AXIS_X = 0;
   localparam int AXIS_Y = 1;
   localparam int NON_MENU_VIEWS = 3;

   cfg_type     cfg;
   axis_state_t axis [2];
   logic        menu_on;
   logic [1:0]  view;
   int          page;
   screen_t     expected_screens [$];
   int          errors;
   int          fires_x;
   int          fires_y;

   function new();
      cfg = '{center_x: 12'd2048, center_y: 12'd2048, deadband: 11'd150,
              initial_delay: 16'd300, repeat_delay: 16'd250, perf_view: 2'd0};
      foreach (axis[a]) axis[a] = '{dir: DIR_NONE, armed: 1'b0, due: 32'd0};
      menu_on = 1'b0;
      view = 2'd0;
      page = 0;
      errors = 0;
      fires_x = 0;
      fires_y = 0;
   endfunction

   function void write_reg(logic [CSR_AW-1:0] idx, logic [CSR_DW-1:0] data);
      case (idx)
         REG_CENTER_X:      cfg.center_x = data[11:0];
         REG_CENTER_Y:      cfg.center_y = data[11:0];
         REG_DEADBAND:      cfg.deadband = data[10:0];
         REG_INITIAL_DELAY: cfg.initial_delay = data;
         REG_REPEAT_DELAY:  cfg.repeat_delay = data;
         REG_PERF_VIEW:     cfg.perf_view = data[1:0];
         default: ;
      endcase
   endfunction

   // hysteresis: enter beyond the deadband, hold while beyond half of it
   function dir_type axis_sense(logic [11:0] sample, logic [11:0] centre, dir_type held);
      int v, c, db, rel;
      v = int'(sample);
      c = int'(centre);
      db = int'(cfg.deadband);
      rel = db / 2;
      if (v < c - db) return DIR_NEG;
      if (v > c + db) return DIR_POS;
      if (held == DIR_NEG && v < c - rel) return DIR_NEG;
      if (held == DIR_POS && v > c + rel) return DIR_POS;
      return DIR_NONE;
   endfunction

   function logic axis_fire(int a, dir_type d, logic [31:0] now);
      if (d != axis[a].dir) begin
         axis[a].dir = d;
         axis[a].armed = 1'b0;
      end
      if (d == DIR_NONE) return 1'b0;
      if (!axis[a].armed || now >= axis[a].due) begin
         axis[a].due = now + (axis[a].armed ? 32'(cfg.repeat_delay) : 32'(cfg.initial_delay));
         axis[a].armed = 1'b1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function void note_sample(joy_sample_t s);
      dir_type d;
      screen_t r;
      r.fired_x = 1'b0;
      r.fired_y = 1'b0;
      if (s.inhibit) begin
         foreach (axis[a]) begin
            axis[a].dir = DIR_NONE;
            axis[a].armed = 1'b0;
         end
      end else begin
         d = axis_sense(s.joy_x, cfg.center_x, axis[AXIS_X].dir);
         r.fired_x = axis_fire(AXIS_X, d, s.now_ms);
         if (r.fired_x) begin
            if (!menu_on) begin
               menu_on = 1'b1;
               view = MENU_VIEW;
            end
            if (d == DIR_NEG) begin
               if (page > 0) page--;
            end else if (page + 1 < PAGES) begin
               page++;
            end
         end
         d = axis_sense(s.joy_y, cfg.center_y, axis[AXIS_Y].dir);
         r.fired_y = axis_fire(AXIS_Y, d, s.now_ms);
         if (r.fired_y) begin
            if (menu_on) begin
               menu_on = 1'b0;
               view = cfg.perf_view;
            end else begin
               view = 2'((int'(view) + ((d == DIR_NEG) ? NON_MENU_VIEWS - 1 : 1))
                         % NON_MENU_VIEWS);
            end
         end
      end
      r.menu_mode = menu_on;
      r.view_mode = view;
      r.active_page = 3'(page);
      expected_screens.push_back(r);
   endfunction

   function void check_screen(screen_t got);
      screen_t want;
      fires_x += got.fired_x;
      fires_y += got.fired_y;
      if (expected_screens.size() == 0) begin
         $error("result item with no sample outstanding");
         errors++;
         return;
      end
      want = expected_screens.pop_front();
      if (got.menu_mode != want.menu_mode) begin
         $error("menu_mode: expected %0d, got %0d", want.menu_mode, got.menu_mode);
         errors++;
      end
      if (got.view_mode != want.view_mode) begin
         $error("view_mode: expected %0d, got %0d", want.view_mode, got.view_mode);
         errors++;
      end
      if (got.active_page != want.active_page) begin
         $error("active_page: expected %0d, got %0d", want.active_page, got.active_page);
         errors++;
      end
      if (got.fired_x != want.fired_x) begin
         $error("fired_x: expected %0d, got %0d", want.fired_x, got.fired_x);
         errors++;
      end
      if (got.fired_y != want.fired_y) begin
         $error("fired_y: expected %0d, got %0d", want.fired_y, got.fired_y);
         errors++;
      end
   endfunction

   function int pending();
      return expected_screens.size();
   endfunction
endclass

module joystick_menu_navigator_unit_test;
   localparam int PHASES = 8;
   localparam int ITEMS_PER_PHASE = 100;
   localparam int STALL_LIMIT = 1000;
   localparam int AXIS_MAX = 4095;
   localparam logic [CSR_AW-1:0] SPARE_REG_A = 3'd6;
   localparam logic [CSR_AW-1:0] SPARE_REG_B = 3'd7;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [11:0]       req_joy_x = '0;
   logic [11:0]       req_joy_y = '0;
   logic              req_inhibit = 1'b0;
   logic [31:0]       req_now_ms = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_menu_mode;
   logic [1:0]        rsp_view_mode;
   logic [2:0]        rsp_active_page;
   logic              rsp_fired_x;
   logic              rsp_fired_y;
   logic              csr_we = 1'b0;
   logic [CSR_AW-1:0] csr_addr = '0;
   logic [CSR_DW-1:0] csr_wdata = '0;

   menu_nav_tracker tracker = new();
   screen_t         seen;
   logic [31:0]     t_ms = '0;
   bit              steady_flow = 1'b0;
   int              stall_left = 0;
   int              idle_cycles = 0;
   int              items_sent = 0;

   joystick_menu_navigator_unit dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic joy_sample_t make_sample(logic [11:0] x, logic [11:0] y, logic inh,
                                               logic [31:0] now);
      joy_sample_t s;
      s.joy_x = x;
      s.joy_y = y;
      s.inhibit = inh;
      s.now_ms = now;
      return s;
   endfunction

   // deflection beyond the deadband, in the hysteresis band, near rest or anywhere
   function automatic logic [11:0] pick_axis(logic [11:0] centre, int lean);
      int db, rel, off, v, sel;
      db = int'(tracker.cfg.deadband);
      rel = db / 2;
      sel = $urandom_range(0, 9);
      case (sel)
         0, 1, 2, 3, 4, 5: off = db + 1 + int'($urandom_range(0, 600));
         6, 7: off = (db > rel) ? rel + 1 + int'($urandom_range(0, db - rel - 1)) : db + 1;
         8: off = int'($urandom_range(0, rel));
         default: return 12'($urandom_range(0, AXIS_MAX));
      endcase
      if (lean == 0) v = int'(centre) + int'($urandom_range(0, 2 * rel)) - rel;
      else v = int'(centre) + lean * off;
      if (v < 0) v = 0;
      if (v > AXIS_MAX) v = AXIS_MAX;
      return 12'(v);
   endfunction

   task automatic send(joy_sample_t s);
      int gap;
      gap = steady_flow ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_joy_x <= s.joy_x;
      req_joy_y <= s.joy_y;
      req_inhibit <= s.inhibit;
      req_now_ms <= s.now_ms;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_sample(s);
      items_sent++;
   endtask

   task automatic set_reg(logic [CSR_AW-1:0] idx, logic [CSR_DW-1:0] data);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= data;
      @(posedge clock);
      tracker.write_reg(idx, data);
   endtask

   task automatic run_directed();
      send(make_sample(12'd2048, 12'd2048, 1'b0, 32'd0));
      send(make_sample(12'd4095, 12'd2048, 1'b0, 32'd0));
      send(make_sample(12'd4095, 12'd2048, 1'b0, 32'd100));
      send(make_sample(12'd4095, 12'd2048, 1'b0, 32'd300));
      // inside the hysteresis band the direction holds, nearer the centre it releases
      send(make_sample(12'd2150, 12'd2048, 1'b0, 32'd550));
      send(make_sample(12'd2100, 12'd2048, 1'b0, 32'd560));
      send(make_sample(12'd2150, 12'd2048, 1'b0, 32'd570));
      send(make_sample(12'd0, 12'd2048, 1'b0, 32'd580));
      send(make_sample(12'd2048, 12'd0, 1'b0, 32'd590));
      send(make_sample(12'd2048, 12'd4095, 1'b0, 32'd600));
      // x and y on the same item
      send(make_sample(12'd4095, 12'd0, 1'b0, 32'd620));
      send(make_sample(12'd4095, 12'd0, 1'b1, 32'd630));
      send(make_sample(12'd4095, 12'd0, 1'b0, 32'd640));
      // due time wraps past the top of the clock
      send(make_sample(12'd0, 12'd4095, 1'b0, 32'hFFFF_FFFF));
      send(make_sample(12'd0, 12'd4095, 1'b0, 32'hFFFF_FFFF));
      send(make_sample(12'd0, 12'd4095, 1'b0, 32'd0));
      // walk into the top page limit
      for (int k = 1; k <= 7; k++)
         send(make_sample(12'd4095, 12'd2048, 1'b0, 32'(k * 1000)));
      t_ms = 32'd8000;
   endtask

   task automatic configure(int p);
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      steady_flow = (p % 3 == 2);
      case (p)
         0: ;
         1: begin
            set_reg(REG_CENTER_X, 16'd0);
            set_reg(REG_CENTER_Y, 16'd4095);
            set_reg(REG_DEADBAND, 16'd0);
            set_reg(REG_INITIAL_DELAY, 16'd0);
            set_reg(REG_REPEAT_DELAY, 16'd0);
            set_reg(REG_PERF_VIEW, 16'd3);
            t_ms = 32'd0;
         end
         2: begin
            set_reg(REG_CENTER_X, 16'd4095);
            set_reg(REG_CENTER_Y, 16'd0);
            set_reg(REG_DEADBAND, 16'd2047);
            set_reg(REG_INITIAL_DELAY, 16'hFFFF);
            set_reg(REG_REPEAT_DELAY, 16'hFFFF);
            set_reg(REG_PERF_VIEW, 16'd2);
            t_ms = 32'hFFFF_0000;
         end
         3: begin
            set_reg(REG_CENTER_X, 16'd2048);
            set_reg(REG_CENTER_Y, 16'd2048);
            set_reg(REG_DEADBAND, 16'd1);
            set_reg(REG_INITIAL_DELAY, 16'd1);
            set_reg(REG_REPEAT_DELAY, 16'd1);
            set_reg(REG_PERF_VIEW, 16'($urandom_range(0, 3)));
         end
         default: begin
            set_reg(SPARE_REG_A, 16'($urandom));
            set_reg(REG_CENTER_X, 16'($urandom_range(1200, 2900)));
            set_reg(REG_CENTER_Y, 16'($urandom_range(1200, 2900)));
            set_reg(REG_DEADBAND, 16'($urandom_range(10, 700)));
            set_reg(REG_INITIAL_DELAY, 16'($urandom_range(0, 600)));
            set_reg(REG_REPEAT_DELAY, 16'($urandom_range(0, 600)));
            set_reg(REG_PERF_VIEW, 16'($urandom_range(0, 3)));
            set_reg(SPARE_REG_B, 16'($urandom));
            if ($urandom_range(0, 1)) t_ms = $urandom;
         end
      endcase
      csr_we <= 1'b0;
   endtask

   // mostly held gestures with advancing time, the rest noise
   task automatic run_phase(int count);
      int sent, lx, ly, len, span, step;
      joy_sample_t s;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 4) != 0) begin
            lx = int'($urandom_range(0, 2)) - 1;
            ly = int'($urandom_range(0, 2)) - 1;
            len = $urandom_range(2, 12);
            span = int'(tracker.cfg.initial_delay);
            if (int'(tracker.cfg.repeat_delay) > span) span = int'(tracker.cfg.repeat_delay);
            span = span / 2 + 8;
            for (int k = 0; k < len; k++) begin
               step = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3 * span)
                                                  : $urandom_range(0, span);
               t_ms = t_ms + 32'(step);
               s.joy_x = pick_axis(tracker.cfg.center_x, lx);
               s.joy_y = pick_axis(tracker.cfg.center_y, ly);
               s.inhibit = ($urandom_range(0, 19) == 0);
               s.now_ms = t_ms;
               send(s);
               sent++;
            end
         end else begin
            s.joy_x = 12'($urandom);
            s.joy_y = 12'($urandom);
            s.inhibit = 1'($urandom_range(0, 1));
            s.now_ms = $urandom_range(0, 1) ? $urandom : t_ms;
            send(s);
            sent++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!steady_flow && $urandom_range(0, 3) == 0) begin
         stall_left = pick_gap();
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen.menu_mode = rsp_menu_mode;
         seen.view_mode = rsp_view_mode;
         seen.active_page = rsp_active_page;
         seen.fired_x = rsp_fired_x;
         seen.fired_y = rsp_fired_y;
         tracker.check_screen(seen);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("joystick_menu_navigator_unit_test: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      for (int p = 0; p < PHASES; p++) begin
         configure(p);
         run_phase(ITEMS_PER_PHASE);
      end
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("%0d joystick samples over %0d register settings", items_sent, PHASES);
      $display("%0d x and %0d y navigation fires checked", tracker.fires_x, tracker.fires_y);
      if (tracker.errors == 0) begin
         $display("joystick_menu_navigator_unit_test: clean");
      end else begin
         $display("joystick_menu_navigator_unit_test: errors");
      end
      $finish;
   end
endmodule
